// ===== design/wsd_pkg.sv =====
// shared types and constants of the websocket frame deframer
// no dependencies; compiled first
package wsd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned OPCODE_W = 4;

    // result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // 7-bit length escapes
    localparam logic [6:0] LEN_ESC_16 = 7'd126;
    localparam logic [6:0] LEN_ESC_64 = 7'd127;

    // extension and key byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        logic                  result_kind;
        logic                  final_fragment;
        logic [OPCODE_W-1:0]   frame_opcode;
        logic                  is_masked;
        logic [LEN_W-1:0]      frame_length;
        logic [KEY_W-1:0]      key_word;
        logic [BYTE_W-1:0]     payload_byte;
        logic                  end_of_frame;
    } result_t;

endpackage

// ===== design/wsd_if.sv =====
// word channels of the deframer: byte stream in, parse results out
// depends on wsd_pkg
interface wsd_byte_if;
    logic                        valid;
    logic                        ready;
    logic [wsd_pkg::BYTE_W-1:0]  stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_result_if;
    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic                          final_fragment;
    logic [wsd_pkg::OPCODE_W-1:0]  frame_opcode;
    logic                          is_masked;
    logic [wsd_pkg::LEN_W-1:0]     frame_length;
    logic [wsd_pkg::KEY_W-1:0]     key_word;
    logic [wsd_pkg::BYTE_W-1:0]    payload_byte;
    logic                          end_of_frame;

    modport source (output valid, output result_kind, output final_fragment,
                    output frame_opcode, output is_masked, output frame_length,
                    output key_word, output payload_byte, output end_of_frame,
                    input ready);
    modport sink   (input valid, input result_kind, input final_fragment,
                    input frame_opcode, input is_masked, input frame_length,
                    input key_word, input payload_byte, input end_of_frame,
                    output ready);
endinterface

// ===== design/websocket_frame_deframer.sv =====
// websocket frame deframer: one received byte per cycle in while the result channel does not stall, parse results out
// timing: a word passes the input register, then the parser's result register
// throughput: one word per cycle unless result ready stalls the parser and, through it, the input register
// reset: asynchronous active low; parser returns to expecting the first header byte
// depends on wsd_pkg, wsd_if, wsd_in_reg, wsd_parser
module websocket_frame_deframer (
    input  logic          clk,
    input  logic          rst_n,
    wsd_byte_if.sink      stream,
    wsd_result_if.source  result
);

    // handshake between the input register and the parser
    logic                        held_valid;
    logic [wsd_pkg::BYTE_W-1:0]  held_byte;
    logic                        take;

    // registered result word
    wsd_pkg::result_t            res;

    // input register decouples the link from parser stalls
    wsd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stream.valid),
        .in_ready   (stream.ready),
        .in_byte    (stream.stream_byte),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .take       (take)
    );

    // header state machine, unmasking and result register;
    // header bytes produce nothing until the header completes
    wsd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .take       (take),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .res        (res)
    );

    // unpack the result word onto the output channel
    assign result.result_kind    = res.result_kind;
    assign result.final_fragment = res.final_fragment;
    assign result.frame_opcode   = res.frame_opcode;
    assign result.is_masked      = res.is_masked;
    assign result.frame_length   = res.frame_length;
    assign result.key_word       = res.key_word;
    assign result.payload_byte   = res.payload_byte;
    assign result.end_of_frame   = res.end_of_frame;

endmodule

// ===== design/wsd_in_reg.sv =====
// input register stage: holds one received word until the parser takes it
// depends on wsd_pkg
module wsd_in_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [wsd_pkg::BYTE_W-1:0]  in_byte,
    output logic                        held_valid,
    output logic [wsd_pkg::BYTE_W-1:0]  held_byte,
    input  logic                        take
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [wsd_pkg::BYTE_W-1:0]  byte_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// ===== design/wsd_parser.sv =====
// frame header parser, payload unmasker and result register
// depends on wsd_pkg
module wsd_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        held_valid,
    input  logic [wsd_pkg::BYTE_W-1:0]  held_byte,
    output logic                        take,
    output logic                        res_valid,
    input  logic                        res_ready,
    output wsd_pkg::result_t            res
);

    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0]                    phase_reg, phase_next;
    logic [3:0]                    cnt_reg, cnt_next;
    logic                          fin_reg, fin_next;
    logic [wsd_pkg::OPCODE_W-1:0]  opcode_reg, opcode_next;
    logic                          mask_reg, mask_next;
    logic [wsd_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [wsd_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [wsd_pkg::LEN_W-1:0]     rem_reg, rem_next;
    logic [1:0]                    kidx_reg, kidx_next;

    logic                          res_valid_reg, res_valid_next;
    wsd_pkg::result_t              res_reg, res_new;

    logic                          emit;
    logic                          len_done;
    logic                          hdr_done;
    logic                          last_byte;
    logic [3:0]                    cnt_dec;
    logic [wsd_pkg::BYTE_W-1:0]    key_byte;

    assign take = held_valid && (!res_valid_reg || res_ready);

    assign cnt_dec   = (cnt_reg != 4'd0) ? cnt_reg - 4'd1 : 4'd0;
    assign last_byte = (rem_reg[wsd_pkg::LEN_W-1:1] == '0);

    always_comb
    begin
        unique case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        rem_next    = rem_reg;
        kidx_next   = kidx_reg;
        emit        = 1'b0;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        res_new     = '0;

        unique case (phase_reg)
            PH_SECOND:
            begin
                mask_next = held_byte[7];
                key_next  = '0;
                if (held_byte[6:0] == wsd_pkg::LEN_ESC_16)
                begin
                    len_next   = '0;
                    phase_next = PH_EXTLEN;
                    cnt_next   = wsd_pkg::EXT16_BYTES;
                end
                else if (held_byte[6:0] == wsd_pkg::LEN_ESC_64)
                begin
                    len_next   = '0;
                    phase_next = PH_EXTLEN;
                    cnt_next   = wsd_pkg::EXT64_BYTES;
                end
                else
                begin
                    len_next = {{(wsd_pkg::LEN_W-7){1'b0}}, held_byte[6:0]};
                    len_done = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                len_next = {len_reg[wsd_pkg::LEN_W-9:0], held_byte};
                cnt_next = cnt_dec;
                len_done = (cnt_dec == 4'd0);
            end
            PH_KEY:
            begin
                key_next = {key_reg[wsd_pkg::KEY_W-9:0], held_byte};
                cnt_next = cnt_dec;
                hdr_done = (cnt_dec == 4'd0);
            end
            PH_PAYLOAD:
            begin
                kidx_next = kidx_reg + 2'd1;
                rem_next  = (rem_reg != '0) ? rem_reg - 64'd1 : rem_reg;
                if (last_byte)
                begin
                    phase_next = PH_FIRST;
                end
                emit                 = 1'b1;
                res_new.result_kind  = wsd_pkg::KIND_PAYLOAD;
                res_new.payload_byte = held_byte ^ key_byte;
                res_new.end_of_frame = last_byte;
            end
            default:
            begin
                // first header byte; unused phase codes land here too
                fin_next    = held_byte[7];
                opcode_next = held_byte[3:0];
                phase_next  = PH_SECOND;
            end
        endcase

        // length known: masked frames go on to the key, unmasked frames complete the header
        if (len_done)
        begin
            if (mask_next)
            begin
                phase_next = PH_KEY;
                cnt_next   = wsd_pkg::KEY_BYTES;
            end
            else
            begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done)
        begin
            rem_next             = len_next;
            kidx_next            = 2'd0;
            phase_next           = (len_next == '0) ? PH_FIRST : PH_PAYLOAD;
            emit                 = 1'b1;
            res_new.result_kind  = wsd_pkg::KIND_HEADER;
            res_new.payload_byte = '0;
            res_new.end_of_frame = (len_next == '0);
        end

        res_new.final_fragment = fin_next;
        res_new.frame_opcode   = opcode_next;
        res_new.is_masked      = mask_next;
        res_new.frame_length   = len_next;
        res_new.key_word       = key_next;
    end

    assign res_valid_next = take ? emit : (res_valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            cnt_reg       <= 4'd0;
            fin_reg       <= 1'b0;
            opcode_reg    <= '0;
            mask_reg      <= 1'b0;
            len_reg       <= '0;
            key_reg       <= '0;
            rem_reg       <= '0;
            kidx_reg      <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                fin_reg    <= fin_next;
                opcode_reg <= opcode_next;
                mask_reg   <= mask_next;
                len_reg    <= len_next;
                key_reg    <= key_next;
                rem_reg    <= rem_next;
                kidx_reg   <= kidx_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            res_reg <= res_new;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
